// ===== hw/rtl/dhfr_pkg.sv =====
// Shared constants for the dual header frame receiver.
`default_nettype none

package dhfr_pkg;

    // Default frame buffer depth in bytes.
    localparam int FRAME_DEPTH_DEF = 64;

    // Largest frame ever accepted, whatever the buffer depth.
    localparam int FRAME_LIMIT = 64;

    // Field and register widths.
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 7;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Shortest frame: two header bytes plus one byte.
    localparam logic [COUNT_W-1:0] MIN_FRAME_LEN = 7'd3;

    // Reset value of the fixed old-protocol frame length.
    localparam logic [COUNT_W-1:0] OLD_LEN_RST = 7'd7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OLD_HEADER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_HEADER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OLD_LENGTH = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/dhfr_frame_mem.sv =====
// Frame byte buffer: one write port and one registered read port.
`default_nettype none

module dhfr_frame_mem #(
    parameter int DEPTH = dhfr_pkg::FRAME_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_wr_en,
    input  wire logic [AW-1:0]                 i_wr_addr,
    input  wire logic [dhfr_pkg::BYTE_W-1:0]   i_wr_data,
    input  wire logic                          i_rd_en,
    input  wire logic [AW-1:0]                 i_rd_addr,
    output logic      [dhfr_pkg::BYTE_W-1:0]   o_rd_data
);

    logic [dhfr_pkg::BYTE_W-1:0] r_mem [DEPTH];

    // Store a received byte.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data is registered and holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dual_header_frame_receiver.sv =====
// Receiver: sequencer that hunts headers, collects frames and drains them beat by beat.
// Rate: one received byte is taken per cycle while hunting or collecting a frame.
// A completed frame drains beat by beat: each beat is a buffer read followed by an output
// that holds until the sink is ready, set by the single buffer read port.
// An oversize frame gives one error beat in the cycle after its deciding byte.
// Reset is synchronous, active low: sequencer and configuration return to defaults.
// The frame buffer is not cleared; only bytes written for the current frame are read.
`default_nettype none

module dual_header_frame_receiver #(
    parameter int FRAME_DEPTH = dhfr_pkg::FRAME_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration write port.
    input  wire logic                              i_cfg_we,
    input  wire logic [dhfr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [dhfr_pkg::CFG_W-1:0]        i_cfg_data,
    // Received bytes.
    input  wire logic                              i_rx_valid,
    output logic                                   o_rx_ready,
    input  wire logic [dhfr_pkg::BYTE_W-1:0]       i_rx_byte,
    // Frame beats.
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic      [dhfr_pkg::BYTE_W-1:0]       o_frame_byte,
    output logic      [dhfr_pkg::INDEX_W-1:0]      o_byte_index,
    output logic                                   o_protocol_new,
    output logic                                   o_status,
    output logic                                   o_last
);

    localparam int CAP = (FRAME_DEPTH < dhfr_pkg::FRAME_LIMIT) ?
                         FRAME_DEPTH : dhfr_pkg::FRAME_LIMIT;
    localparam int AW  = $clog2(CAP);
    localparam int CW  = dhfr_pkg::COUNT_W;
    localparam int BW  = dhfr_pkg::BYTE_W;
    localparam logic [CW-1:0] CAP_C  = CW'(CAP);
    localparam logic [BW:0]   CAP_W  = (BW+1)'(CAP);

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_HEAD,
        ST_BODY,
        ST_FETCH,
        ST_SHOW
    } t_state;

    // Configuration registers.
    logic [dhfr_pkg::CFG_W-1:0] r_old_header;
    logic [dhfr_pkg::CFG_W-1:0] r_new_header;
    logic [CW-1:0]              r_old_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_old_header <= '0;
            r_new_header <= '0;
            r_old_len    <= dhfr_pkg::OLD_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dhfr_pkg::CFG_OLD_HEADER: r_old_header <= i_cfg_data;
                dhfr_pkg::CFG_NEW_HEADER: r_new_header <= i_cfg_data;
                dhfr_pkg::CFG_OLD_LENGTH: r_old_len    <= i_cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer state.
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_target, n_target;
    logic            r_is_new, n_is_new;
    logic [BW-1:0]   r_held, n_held;
    logic [CW-1:0]   r_ptr, n_ptr;
    logic            r_status, n_status;

    // Buffer ports.
    logic            w_wr_en;
    logic [AW-1:0]   w_wr_addr;
    logic            w_rd_en;
    logic [BW-1:0]   w_rd_data;

    // Header byte compare operands.
    logic [BW-1:0]   w_old_hi, w_old_lo, w_new_hi, w_new_lo;
    logic            w_sel_old;
    logic [BW-1:0]   w_hi, w_lo;
    logic [CW-1:0]   w_old_target;
    logic [CW-1:0]   w_count_inc;
    logic [BW:0]     w_new_target;
    logic [CW-1:0]   w_eff_target;
    logic            w_rx_beat, w_out_beat, w_out_end;

    assign w_old_hi  = r_old_header[2*BW-1:BW];
    assign w_old_lo  = r_old_header[BW-1:0];
    assign w_new_hi  = r_new_header[2*BW-1:BW];
    assign w_new_lo  = r_new_header[BW-1:0];
    assign w_sel_old = (r_held == w_old_hi);
    assign w_hi      = w_sel_old ? w_old_hi : w_new_hi;
    assign w_lo      = w_sel_old ? w_old_lo : w_new_lo;

    assign w_old_target = (r_old_len < dhfr_pkg::MIN_FRAME_LEN) ?
                          dhfr_pkg::MIN_FRAME_LEN : r_old_len;
    assign w_count_inc  = r_count + CW'(1);
    assign w_new_target = {1'b0, i_rx_byte} + (BW+1)'(dhfr_pkg::MIN_FRAME_LEN);

    assign o_rx_ready  = (r_state == ST_HUNT) || (r_state == ST_HEAD) ||
                         (r_state == ST_BODY);
    assign w_rx_beat   = i_rx_valid && o_rx_ready;
    assign o_out_valid = (r_state == ST_SHOW);
    assign w_out_beat  = o_out_valid && i_out_ready;
    assign w_out_end   = r_status || ((r_ptr + CW'(1)) == r_target);

    // Next-state logic for hunting, collecting and draining.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_target     = r_target;
        n_is_new     = r_is_new;
        n_held       = r_held;
        n_ptr        = r_ptr;
        n_status     = r_status;
        w_wr_en      = 1'b0;
        w_wr_addr    = '0;
        w_eff_target = r_target;
        case (r_state)
            ST_HUNT: begin
                if (w_rx_beat) begin
                    n_count = '0;
                    if ((i_rx_byte == w_old_hi) || (i_rx_byte == w_new_hi)) begin
                        n_held  = i_rx_byte;
                        w_wr_en = 1'b1;
                        n_state = ST_HEAD;
                    end
                end
            end
            ST_HEAD: begin
                if (w_rx_beat) begin
                    if (i_rx_byte == w_lo) begin
                        w_wr_en   = 1'b1;
                        w_wr_addr = AW'(1);
                        n_is_new  = !w_sel_old;
                        n_count   = CW'(2);
                        if (w_sel_old) begin
                            n_target = w_old_target;
                            if (w_old_target > CAP_C) begin
                                n_state  = ST_SHOW;
                                n_status = 1'b1;
                                n_ptr    = '0;
                                n_count  = '0;
                            end else begin
                                n_state = ST_BODY;
                            end
                        end else begin
                            n_target = dhfr_pkg::MIN_FRAME_LEN;
                            n_state  = ST_BODY;
                        end
                    end else if (i_rx_byte == w_hi) begin
                        n_held  = i_rx_byte;
                        w_wr_en = 1'b1;
                    end else begin
                        n_state = ST_HUNT;
                        n_count = '0;
                    end
                end
            end
            ST_BODY: begin
                if (w_rx_beat) begin
                    if (r_count >= CAP_C) begin
                        n_state = ST_HUNT;
                        n_count = '0;
                    end else begin
                        w_wr_en   = 1'b1;
                        w_wr_addr = r_count[AW-1:0];
                        n_count   = w_count_inc;
                        // The length byte of the new protocol sets the frame size.
                        if (r_is_new && (w_count_inc == dhfr_pkg::MIN_FRAME_LEN)) begin
                            w_eff_target = w_new_target[CW-1:0];
                            n_target     = w_new_target[CW-1:0];
                        end
                        if (r_is_new && (w_count_inc == dhfr_pkg::MIN_FRAME_LEN) &&
                            (w_new_target > CAP_W)) begin
                            n_state  = ST_SHOW;
                            n_status = 1'b1;
                            n_ptr    = '0;
                            n_count  = '0;
                        end else if (w_count_inc >= w_eff_target) begin
                            n_state  = ST_FETCH;
                            n_status = 1'b0;
                            n_ptr    = '0;
                        end
                    end
                end
            end
            ST_FETCH: begin
                n_state = ST_SHOW;
            end
            ST_SHOW: begin
                if (w_out_beat) begin
                    if (w_out_end) begin
                        n_state  = ST_HUNT;
                        n_count  = '0;
                        n_status = 1'b0;
                    end else begin
                        n_ptr   = r_ptr + CW'(1);
                        n_state = ST_FETCH;
                    end
                end
            end
            default: begin
                n_state = ST_HUNT;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_HUNT;
            r_count  <= '0;
            r_target <= '0;
            r_is_new <= 1'b0;
            r_ptr    <= '0;
            r_status <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_target <= n_target;
            r_is_new <= n_is_new;
            r_ptr    <= n_ptr;
            r_status <= n_status;
        end
        r_held <= n_held;
    end

    assign w_rd_en = (r_state == ST_FETCH);

    dhfr_frame_mem #(
        .DEPTH (CAP),
        .AW    (AW)
    ) u_frame_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (i_rx_byte),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_ptr[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    // Beat payload; an error beat carries zero data.
    assign o_frame_byte   = r_status ? '0 : w_rd_data;
    assign o_byte_index   = r_ptr[dhfr_pkg::INDEX_W-1:0];
    assign o_protocol_new = r_is_new;
    assign o_status       = r_status;
    assign o_last         = w_out_end;

    // The stored byte count never passes the buffer size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("byte count beyond buffer size");

    // The receive side and the drain side are never active together.
    a_side_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_rx_ready && o_out_valid))
        else $error("receive and drain active together");

    // An error beat is always the last beat of its frame.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_last && (o_byte_index == '0)))
        else $error("error beat not marked last");

    // Draining reads only bytes inside the current frame.
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FETCH) |-> (r_ptr < r_target))
        else $error("read beyond frame end");

    // After the final beat the block hunts again.
    a_end_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last) |=> (r_state == ST_HUNT))
        else $error("no return to hunt after final beat");

endmodule

`default_nettype wire

// ===== tb/frame_beat_checker.sv =====
// Frame beat checker: predicts the receiver's output beats and compares them.
`timescale 1ns / 100ps

module frame_beat_checker #(
    parameter int FRAME_DEPTH = dhfr_pkg::FRAME_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [dhfr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [dhfr_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire logic                              i_rx_valid,
    input  wire logic                              i_rx_ready,
    input  wire logic [dhfr_pkg::BYTE_W-1:0]       i_rx_byte,
    input  wire logic                              i_out_valid,
    input  wire logic                              i_out_ready,
    input  wire logic [dhfr_pkg::BYTE_W-1:0]       i_frame_byte,
    input  wire logic [dhfr_pkg::INDEX_W-1:0]      i_byte_index,
    input  wire logic                              i_protocol_new,
    input  wire logic                              i_status,
    input  wire logic                              i_last,
    output int                                     o_fail_count,
    output int                                     o_pending
);

    // Largest frame the receiver keeps.
    localparam int CAP = (FRAME_DEPTH < dhfr_pkg::FRAME_LIMIT) ?
                         FRAME_DEPTH : dhfr_pkg::FRAME_LIMIT;

    typedef enum logic [1:0] {
        SEEK_HEADER,
        HEADER_HELD,
        COLLECT_BODY
    } t_parse_phase;

    typedef struct packed {
        logic [dhfr_pkg::BYTE_W-1:0]  data;
        logic [dhfr_pkg::INDEX_W-1:0] index;
        logic                         proto_new;
        logic                         too_long;
        logic                         last;
    } t_frame_beat;

    // Mirrored configuration.
    logic [dhfr_pkg::CFG_W-1:0]   old_hdr;
    logic [dhfr_pkg::CFG_W-1:0]   new_hdr;
    logic [dhfr_pkg::COUNT_W-1:0] old_len;

    // Mirrored parser state.
    t_parse_phase                 phase;
    int                           stored;
    int                           frame_len;
    logic                         cur_new;
    logic [dhfr_pkg::BYTE_W-1:0]  frame_copy [0:CAP-1];

    t_frame_beat                  expected_beats [$];
    int                           mismatches = 0;

    assign o_fail_count = mismatches;

    // An oversize frame gives a single error beat and restarts the hunt.
    function automatic void push_overflow();
        t_frame_beat beat;
        beat = '{data: '0, index: '0, proto_new: cur_new, too_long: 1'b1, last: 1'b1};
        expected_beats.push_back(beat);
        phase = SEEK_HEADER;
        stored = 0;
    endfunction

    // A completed frame drains one beat per stored byte.
    function automatic void push_frame();
        t_frame_beat beat;
        int n;
        n = (frame_len > CAP) ? CAP : frame_len;
        for (int i = 0; i < n; i++) begin
            beat.data      = frame_copy[i];
            beat.index     = i[dhfr_pkg::INDEX_W-1:0];
            beat.proto_new = cur_new;
            beat.too_long  = 1'b0;
            beat.last      = (i + 1 == n);
            expected_beats.push_back(beat);
        end
        phase = SEEK_HEADER;
        stored = 0;
    endfunction

    // Advance the parser by one received byte.
    function automatic void predict_rx_byte(input logic [dhfr_pkg::BYTE_W-1:0] b);
        logic [dhfr_pkg::BYTE_W-1:0] hi;
        logic [dhfr_pkg::BYTE_W-1:0] lo;
        logic                        pn;
        case (phase)
            SEEK_HEADER: begin
                if (b == old_hdr[15:8] || b == new_hdr[15:8]) begin
                    frame_copy[0] = b;
                    phase = HEADER_HELD;
                end
                stored = 0;
            end
            HEADER_HELD: begin
                // The held high byte decides which header is tried, old first.
                if (frame_copy[0] == old_hdr[15:8]) begin
                    {hi, lo} = old_hdr;
                    pn = 1'b0;
                end else begin
                    {hi, lo} = new_hdr;
                    pn = 1'b1;
                end
                if (b == lo) begin
                    frame_copy[1] = b;
                    cur_new = pn;
                    stored = 2;
                    phase = COLLECT_BODY;
                    if (!pn) begin
                        frame_len = (old_len < dhfr_pkg::MIN_FRAME_LEN) ?
                                    int'(dhfr_pkg::MIN_FRAME_LEN) : int'(old_len);
                        if (frame_len > CAP)
                            push_overflow();
                    end else begin
                        frame_len = 3;
                    end
                end else if (b == hi) begin
                    frame_copy[0] = b;
                end else begin
                    phase = SEEK_HEADER;
                    stored = 0;
                end
            end
            COLLECT_BODY: begin
                if (stored >= CAP) begin
                    phase = SEEK_HEADER;
                    stored = 0;
                    return;
                end
                frame_copy[stored] = b;
                stored++;
                // The length byte of the new protocol sets the frame size.
                if (cur_new && stored == 3) begin
                    frame_len = int'(b) + 3;
                    if (frame_len > CAP) begin
                        push_overflow();
                        return;
                    end
                end
                if (stored >= frame_len)
                    push_frame();
            end
            default: begin
                phase = SEEK_HEADER;
                stored = 0;
            end
        endcase
    endfunction

    function automatic void cmp_field(input string name, input logic [7:0] expv,
                                      input logic [7:0] actv);
        if (actv !== expv) begin
            $error("%s: expected %0h, got %0h", name, expv, actv);
            mismatches++;
        end
    endfunction

    // Compare an accepted beat with the oldest prediction.
    function automatic void check_beat();
        t_frame_beat exp_beat;
        if (expected_beats.size() == 0) begin
            $error("unexpected beat: frame_byte %0h byte_index %0d status %0b",
                   i_frame_byte, i_byte_index, i_status);
            mismatches++;
            return;
        end
        exp_beat = expected_beats.pop_front();
        cmp_field("frame_byte", exp_beat.data, i_frame_byte);
        cmp_field("byte_index", 8'(exp_beat.index), 8'(i_byte_index));
        cmp_field("protocol_new", 8'(exp_beat.proto_new), 8'(i_protocol_new));
        cmp_field("status", 8'(exp_beat.too_long), 8'(i_status));
        cmp_field("last", 8'(exp_beat.last), 8'(i_last));
    endfunction

    // Watch both channels and the register port at every rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            old_hdr = '0;
            new_hdr = '0;
            old_len = dhfr_pkg::OLD_LEN_RST;
            phase = SEEK_HEADER;
            stored = 0;
            frame_len = 0;
            cur_new = 1'b0;
            expected_beats.delete();
        end else begin
            if (i_out_valid && i_out_ready)
                check_beat();
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    dhfr_pkg::CFG_OLD_HEADER: old_hdr = i_cfg_data;
                    dhfr_pkg::CFG_NEW_HEADER: new_hdr = i_cfg_data;
                    dhfr_pkg::CFG_OLD_LENGTH: old_len = i_cfg_data[dhfr_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_rx_valid && i_rx_ready)
                predict_rx_byte(i_rx_byte);
        end
        o_pending <= expected_beats.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top: clock, reset, stimulus and verdict for the dual header frame receiver.
`timescale 1ns / 100ps

module tb_top;

    localparam int  HALF_PERIOD = 6;
    localparam int  SETTLE      = 8;
    localparam int  SEG_ITEMS   = 55;
    localparam time RUN_LIMIT   = 20_000_000;

    // Hand-picked bytes under the first register setting.
    localparam int N_DIRECTED = 25;
    localparam logic [N_DIRECTED*8-1:0] DIRECTED = {
        8'h00, 8'hAA, 8'hAA, 8'h55, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
        8'hEB, 8'h90, 8'h00,
        8'hEB, 8'h90, 8'h01, 8'hFF,
        8'hEB, 8'h90, 8'h3E,
        8'hEB, 8'h12,
        8'hAA, 8'hEB,
        8'h7F, 8'h80
    };

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [dhfr_pkg::CFG_IDX_W-1:0] cfg_idx = dhfr_pkg::CFG_OLD_HEADER;
    logic [dhfr_pkg::CFG_W-1:0]     cfg_data = '0;
    logic                           rx_valid = 1'b0;
    logic [dhfr_pkg::BYTE_W-1:0]    rx_byte = '0;
    logic                           out_ready = 1'b0;

    logic                           rx_ready;
    logic                           out_valid;
    logic [dhfr_pkg::BYTE_W-1:0]    frame_byte;
    logic [dhfr_pkg::INDEX_W-1:0]   byte_index;
    logic                           protocol_new;
    logic                           status;
    logic                           last;

    int                             fail_count;
    int                             pending;
    int                             send_idle_pct = 0;
    int                             recv_idle_pct = 0;
    int                             items_sent = 0;

    // Stimulus-side copy of the current registers, used to build frames.
    logic [dhfr_pkg::CFG_W-1:0]     old_hdr_cfg;
    logic [dhfr_pkg::CFG_W-1:0]     new_hdr_cfg;
    logic [dhfr_pkg::COUNT_W-1:0]   old_len_cfg;

    always #(HALF_PERIOD) clk = ~clk;

    dual_header_frame_receiver #(
        .FRAME_DEPTH (dhfr_pkg::FRAME_DEPTH_DEF)
    ) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_rx_valid     (rx_valid),
        .o_rx_ready     (rx_ready),
        .i_rx_byte      (rx_byte),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_frame_byte   (frame_byte),
        .o_byte_index   (byte_index),
        .o_protocol_new (protocol_new),
        .o_status       (status),
        .o_last         (last)
    );

    frame_beat_checker #(
        .FRAME_DEPTH (dhfr_pkg::FRAME_DEPTH_DEF)
    ) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_rx_valid     (rx_valid),
        .i_rx_ready     (rx_ready),
        .i_rx_byte      (rx_byte),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_frame_byte   (frame_byte),
        .i_byte_index   (byte_index),
        .i_protocol_new (protocol_new),
        .i_status       (status),
        .i_last         (last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // The sink stalls at random, at the rate the current phase sets.
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one byte, after a random gap, and hold it until it is taken.
    task automatic send_byte(input logic [dhfr_pkg::BYTE_W-1:0] b);
        if ($urandom_range(99) < send_idle_pct) begin
            rx_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        rx_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (!rx_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Stop sending and wait until every predicted beat has come out.
    task automatic wait_drained();
        rx_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    // Load one register setting while the receiver is idle.
    task automatic apply_setting(input int k);
        case (k)
            0: begin old_hdr_cfg = 16'hAA55; new_hdr_cfg = 16'hEB90; old_len_cfg = 7'd7;   end
            1: begin old_hdr_cfg = 16'hFFFF; new_hdr_cfg = 16'h0000; old_len_cfg = 7'd64;  end
            2: begin old_hdr_cfg = 16'h0000; new_hdr_cfg = 16'hFFFF; old_len_cfg = 7'd3;   end
            3: begin old_hdr_cfg = 16'h1234; new_hdr_cfg = 16'h12AB; old_len_cfg = 7'd0;   end
            4: begin old_hdr_cfg = 16'h5A5A; new_hdr_cfg = 16'hC33C; old_len_cfg = 7'd127; end
            5: begin old_hdr_cfg = 16'h7E81; new_hdr_cfg = 16'h8181; old_len_cfg = 7'd2;   end
            default: begin
                old_hdr_cfg = 16'h3C00; new_hdr_cfg = 16'h00FF; old_len_cfg = 7'd65;
            end
        endcase
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= dhfr_pkg::CFG_OLD_HEADER;
        cfg_data <= old_hdr_cfg;
        @(posedge clk);
        cfg_idx <= dhfr_pkg::CFG_NEW_HEADER;
        cfg_data <= new_hdr_cfg;
        @(posedge clk);
        cfg_idx <= dhfr_pkg::CFG_OLD_LENGTH;
        cfg_data <= {{(dhfr_pkg::CFG_W-dhfr_pkg::COUNT_W){1'b0}}, old_len_cfg};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly well-formed frames with random content, some broken headers and noise.
    task automatic send_random_frame();
        int kind;
        int body_len;
        int pick;
        logic [dhfr_pkg::BYTE_W-1:0] hi;
        logic [dhfr_pkg::BYTE_W-1:0] lo;
        kind = $urandom_range(99);
        if (kind < 80) begin
            {hi, lo} = (kind < 40) ? old_hdr_cfg : new_hdr_cfg;
            if ($urandom_range(7) == 0)
                send_byte(hi);
            send_byte(hi);
            send_byte(lo);
            if (kind < 40) begin
                body_len = (old_len_cfg < dhfr_pkg::MIN_FRAME_LEN) ?
                           int'(dhfr_pkg::MIN_FRAME_LEN) : int'(old_len_cfg);
                if (body_len <= dhfr_pkg::FRAME_LIMIT)
                    repeat (body_len - 2) send_byte(8'($urandom_range(255)));
            end else begin
                // Length byte: mostly short, sometimes the largest fit or too long.
                pick = $urandom_range(19);
                if (pick == 0)
                    body_len = dhfr_pkg::FRAME_LIMIT - 3;
                else if (pick == 1)
                    body_len = $urandom_range(255, dhfr_pkg::FRAME_LIMIT - 2);
                else
                    body_len = $urandom_range(12);
                send_byte(8'(body_len));
                if (body_len + 3 <= dhfr_pkg::FRAME_LIMIT)
                    repeat (body_len) send_byte(8'($urandom_range(255)));
            end
        end else if (kind < 90) begin
            send_byte($urandom_range(1) ? old_hdr_cfg[15:8] : new_hdr_cfg[15:8]);
            send_byte(8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
        end
    endtask

    // Main stimulus sequence and verdict.
    initial begin
        int seg_start;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 9;
        recv_idle_pct <= 67;

        apply_setting(0);
        for (int i = 0; i < N_DIRECTED; i++)
            send_byte(DIRECTED[(N_DIRECTED - 1 - i) * 8 +: 8]);

        for (int seg = 1; seg <= 6; seg++) begin
            // Swap the idle rates halfway, then run without idling.
            if (seg == 3) begin
                send_idle_pct = 67;
                recv_idle_pct <= 9;
            end else if (seg == 5) begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            apply_setting(seg);
            seg_start = items_sent;
            while (items_sent - seg_start < SEG_ITEMS) begin
                send_random_frame();
                if ($urandom_range(24) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (2 * SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #(RUN_LIMIT);
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/dhfr_pkg.sv
hw/rtl/dhfr_frame_mem.sv
hw/rtl/dual_header_frame_receiver.sv
tb/frame_beat_checker.sv
tb/tb_top.sv
